>>> rtl/core/saq_pkg.sv
// shared types, constants and control structs of the sorted alarm queue
`timescale 1ns / 1ps

package saq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int RESULT_LIMIT    = 16;
	localparam int TICK_W          = 32;
	localparam int ID_W            = 8;
	localparam int KIND_W          = 2;
	localparam int FIRED_W         = $clog2(RESULT_LIMIT + 1);

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	localparam logic [KIND_W-1:0] KIND_SET_OK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SET_FULL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

	typedef struct packed {
		logic [TICK_W-1:0] tick;
		logic [ID_W-1:0]   id;
	} entry_t;

	typedef enum logic [2:0] {
		IDX_HOLD  = 3'd0,
		IDX_COUNT = 3'd1,
		IDX_ZERO  = 3'd2,
		IDX_INC   = 3'd3,
		IDX_DEC   = 3'd4
	} idx_op_t;

	typedef struct packed {
		logic              load;
		logic              rd_en;
		logic              rd_prev;
		logic              wr_en;
		logic              wr_at_pos;
		logic              wr_new;
		idx_op_t           idx_op;
		logic              pos_load;
		logic              pos_inc;
		logic              fired_clr;
		logic              fired_inc;
		logic              pend_load;
		logic              count_inc;
		logic              count_sub;
		logic              emit;
		logic [KIND_W-1:0] emit_kind;
		logic              emit_pend;
		logic              emit_last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic idx_zero;
		logic idx_at_count;
		logic rd_lt_key;
		logic rd_eq_key;
		logic fired_zero;
		logic fired_at_limit;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/core/saq_datapath.sv
// queue memory, walk pointers, pending fired id and output register
`timescale 1ns / 1ps

module saq_datapath import saq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              operation,
	input  logic [TICK_W-1:0] alarm_tick,
	input  logic [ID_W-1:0]   callback_id,
	input  logic [TICK_W-1:0] system_tick,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [KIND_W-1:0] result_kind,
	output logic [ID_W-1:0]   fired_callback,
	output logic              last_result
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	entry_t              mem_q [QUEUE_DEPTH];
	entry_t              rdata_q;
	logic [TICK_W-1:0]   key_q;
	logic [ID_W-1:0]     new_id_q;
	logic [ID_W-1:0]     pend_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       pos_q;
	logic [CW-1:0]       count_q;
	logic [FIRED_W-1:0]  fired_q;
	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [ID_W-1:0]     cb_q;
	logic                last_q;

	logic [CW-1:0]       rd_idx;
	logic [CW-1:0]       wr_idx;
	entry_t              wr_data;

	assign rd_idx  = cmd.rd_prev ? idx_q - 1'b1 : idx_q;
	assign wr_idx  = cmd.wr_at_pos ? pos_q : idx_q;
	assign wr_data = cmd.wr_new ? entry_t'{tick: key_q, id: new_id_q} : rdata_q;

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_idx[AW-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= (operation == OP_CHECK) ? system_tick : alarm_tick;
			new_id_q <= callback_id;
		end
		if (cmd.pend_load) begin
			pend_q <= rdata_q.id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pos_q   <= '0;
			count_q <= '0;
			fired_q <= '0;
		end else begin
			case (cmd.idx_op)
				IDX_HOLD:  idx_q <= idx_q;
				IDX_COUNT: idx_q <= count_q;
				IDX_ZERO:  idx_q <= '0;
				IDX_INC:   idx_q <= idx_q + 1'b1;
				IDX_DEC:   idx_q <= idx_q - 1'b1;
				default:   idx_q <= idx_q;
			endcase
			if (cmd.pos_load) begin
				pos_q <= idx_q;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.count_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.count_sub) begin
				count_q <= count_q - CW'(fired_q);
			end
			if (cmd.fired_clr) begin
				fired_q <= '0;
			end else if (cmd.fired_inc) begin
				fired_q <= fired_q + 1'b1;
			end
		end
	end

	// output register, refilled in the cycle its beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= cmd.emit_kind;
			cb_q   <= cmd.emit_pend ? pend_q : '0;
			last_q <= cmd.emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign fired_callback = cb_q;
	assign last_result    = last_q;

	assign sts.full           = (count_q == CW'(QUEUE_DEPTH));
	assign sts.idx_zero       = (idx_q == '0);
	assign sts.idx_at_count   = (idx_q == count_q);
	assign sts.rd_lt_key      = (rdata_q.tick < key_q);
	assign sts.rd_eq_key      = (rdata_q.tick == key_q);
	assign sts.fired_zero     = (fired_q == '0);
	assign sts.fired_at_limit = (fired_q == FIRED_W'(RESULT_LIMIT));
	assign sts.out_free       = !out_valid_q || out_ready;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_fired_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fired_q <= FIRED_W'(RESULT_LIMIT))
		else $error("fired count above result limit");

	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> rd_idx < count_q)
		else $error("read of an entry beyond the fill level");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.wr_at_pos) |-> pos_q < idx_q)
		else $error("compaction destination not behind source");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result written over an untaken beat");

endmodule

>>> rtl/core/saq_ctrl.sv
// controller sequencing insert, fire scan and compaction walks
`timescale 1ns / 1ps

module saq_ctrl import saq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic operation,
	input  sts_t sts,
	output logic in_ready,
	output cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b0000000001,
		ST_SET_RD    = 10'b0000000010,
		ST_SET_EV    = 10'b0000000100,
		ST_RESP_OK   = 10'b0000001000,
		ST_RESP_FULL = 10'b0000010000,
		ST_CHK_RD    = 10'b0000100000,
		ST_CHK_EV    = 10'b0001000000,
		ST_CHK_END   = 10'b0010000000,
		ST_CMP_RD    = 10'b0100000000,
		ST_CMP_WR    = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.idx_op = IDX_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (operation == OP_SET) begin
						cmd.idx_op = IDX_COUNT;
						state_d    = sts.full ? ST_RESP_FULL : ST_SET_RD;
					end else begin
						cmd.idx_op    = IDX_ZERO;
						cmd.fired_clr = 1'b1;
						state_d       = ST_CHK_RD;
					end
				end
			end
			// walk from the tail, shifting entries up until the slot is found
			ST_SET_RD: begin
				if (sts.idx_zero) begin
					cmd.wr_en     = 1'b1;
					cmd.wr_new    = 1'b1;
					cmd.count_inc = 1'b1;
					state_d       = ST_RESP_OK;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_prev = 1'b1;
					state_d     = ST_SET_EV;
				end
			end
			ST_SET_EV: begin
				cmd.wr_en = 1'b1;
				if (!sts.rd_lt_key) begin
					cmd.idx_op = IDX_DEC;
					state_d    = ST_SET_RD;
				end else begin
					cmd.wr_new    = 1'b1;
					cmd.count_inc = 1'b1;
					state_d       = ST_RESP_OK;
				end
			end
			ST_RESP_OK: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_SET_OK;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_RESP_FULL: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_SET_FULL;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_CHK_RD: begin
				if (sts.idx_at_count || sts.fired_at_limit) begin
					state_d = ST_CHK_END;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_CHK_EV;
				end
			end
			// each fired id waits in a holding register until we know if it is the last
			ST_CHK_EV: begin
				if (sts.rd_lt_key) begin
					cmd.idx_op = IDX_INC;
					state_d    = ST_CHK_RD;
				end else if (sts.rd_eq_key) begin
					if (sts.fired_zero) begin
						cmd.pos_load  = 1'b1;
						cmd.pend_load = 1'b1;
						cmd.fired_inc = 1'b1;
						cmd.idx_op    = IDX_INC;
						state_d       = ST_CHK_RD;
					end else if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_FIRED;
						cmd.emit_pend = 1'b1;
						cmd.pend_load = 1'b1;
						cmd.fired_inc = 1'b1;
						cmd.idx_op    = IDX_INC;
						state_d       = ST_CHK_RD;
					end
				end else begin
					state_d = ST_CHK_END;
				end
			end
			ST_CHK_END: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					if (sts.fired_zero) begin
						cmd.emit_kind = KIND_NONE;
						state_d       = ST_IDLE;
					end else begin
						cmd.emit_kind = KIND_FIRED;
						cmd.emit_pend = 1'b1;
						state_d       = ST_CMP_RD;
					end
				end
			end
			// close the gap left by fired entries
			ST_CMP_RD: begin
				if (sts.idx_at_count) begin
					cmd.count_sub = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_CMP_WR;
				end
			end
			ST_CMP_WR: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_at_pos = 1'b1;
				cmd.pos_inc   = 1'b1;
				cmd.idx_op    = IDX_INC;
				state_d       = ST_CMP_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q != ST_IDLE)
		else $error("accepted beat left controller idle");

	a_wr_rd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.wr_en))
		else $error("read and write issued in the same cycle");

	a_count_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_inc |=> state_q == ST_RESP_OK)
		else $error("insert finished without a set response");

endmodule

>>> rtl/core/sorted_alarm_queue_unit.sv
// top level of the sorted alarm queue: controller plus datapath
//
//  channel | handshake           | payload
//  in      | in_valid / in_ready   | operation, alarm_tick, callback_id, system_tick
//  out     | out_valid / out_ready | result_kind, fired_callback, last_result
//
// after an accepted set beat in_ready stays low while entries are shifted up and
// the response is sent; a refused set keeps it low until its response is sent. a
// check beat keeps it low while the walk reads entries and while the entries behind
// the fired ones are moved up; the single-port queue memory with its registered
// read sets the pace. reset empties the queue at once, memory contents are left
// as they are. a stalled out_ready holds the walk only when a new result needs
// the output register.
`timescale 1ns / 1ps

module sorted_alarm_queue_unit import saq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [TICK_W-1:0] alarm_tick,
	input  logic [ID_W-1:0]   callback_id,
	input  logic [TICK_W-1:0] system_tick,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] result_kind,
	output logic [ID_W-1:0]   fired_callback,
	output logic              last_result
);

	cmd_t cmd;
	sts_t sts;

	saq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.sts       (sts),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	saq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.alarm_tick     (alarm_tick),
		.callback_id    (callback_id),
		.system_tick    (system_tick),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.result_kind    (result_kind),
		.fired_callback (fired_callback),
		.last_result    (last_result)
	);

endmodule
